FILE: rtl/oaie_pkg.sv
// Package for the ordered array block: capacity, field widths, request kinds,
// status codes and the control word broadcast along the cell row.
// No dependencies.
`timescale 1ns / 1ps

package oaie_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_ERASE  = 3'd2,
    KIND_READ   = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ERASE
  } cell_op_e;

  typedef struct packed {
    cell_op_e                 op;
    logic [IDX_W-1:0]         pos;
    logic signed [WORD_W-1:0] value;
  } cell_ctrl_t;

endpackage

FILE: rtl/oaie_if.sv
// Handshake interfaces for requests and responses of the ordered array block.
// Depends on oaie_pkg.
`timescale 1ns / 1ps

interface oaie_req_if
  import oaie_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [IDX_W-1:0]         index;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output kind, output index, output value, input ready);
  modport sink   (input valid, input kind, input index, input value, output ready);
endinterface

interface oaie_rsp_if
  import oaie_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [WORD_W-1:0] read_value;
  logic [CNT_W-1:0]         count;

  modport source (output valid, output status, output read_value, output count, input ready);
  modport sink   (input valid, input status, input read_value, input count, output ready);
endinterface

FILE: rtl/oaie_cell.sv
// One storage cell of the ordered array row: holds a word, takes the new value or
// a neighbour on insert or erase, and taps its word out on a position match.
// Depends on oaie_pkg.
`timescale 1ns / 1ps

module oaie_cell
  import oaie_pkg::*;
(
  input  logic                     clk_i,
  input  cell_ctrl_t               ctrl_i,
  input  logic [IDX_W-1:0]         pos_i,
  input  logic signed [WORD_W-1:0] left_i,
  input  logic signed [WORD_W-1:0] right_i,
  output logic signed [WORD_W-1:0] data_o,
  output logic signed [WORD_W-1:0] tap_o
);

  logic signed [WORD_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (pos_i == ctrl_i.pos) begin
          data_d = ctrl_i.value;
        end else if (pos_i > ctrl_i.pos) begin
          data_d = left_i;
        end
      end
      CELL_ERASE: begin
        if (pos_i >= ctrl_i.pos) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign tap_o  = (pos_i == ctrl_i.pos) ? data_q : '0;

endmodule

FILE: rtl/ordered_array_insert_erase.sv
// Ordered array of signed words with insert, erase, append, read and clear.
// An accepted request's response is in the output register in the next cycle.
// One item per cycle unless an untaken response stalls it; the cells shift on accept.
// Reset clears the entry count and the response valid; the cell words are
// not cleared and are only ever read after being written.
`timescale 1ns / 1ps

module ordered_array_insert_erase
  import oaie_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  oaie_req_if.sink   req_i,
  oaie_rsp_if.source rsp_o
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]         count_q, count_d;
  logic                     out_valid_q;
  status_e                  status_q, status_d;
  logic signed [WORD_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0]         out_count_q;

  logic                     accept;
  logic                     full;
  logic [CNT_W-1:0]         idx_ext;
  cell_ctrl_t               ctrl;
  logic signed [WORD_W-1:0] tap_or;

  logic signed [WORD_W-1:0] cell_data [CAPACITY];
  logic signed [WORD_W-1:0] cell_tap  [CAPACITY];

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign full        = (count_q == CAP_CNT);
  assign idx_ext     = CNT_W'(req_i.index);

  always_comb begin
    tap_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tap_or = tap_or | cell_tap[i];
    end
  end

  always_comb begin
    ctrl.op    = CELL_HOLD;
    ctrl.pos   = req_i.index;
    ctrl.value = req_i.value;
    case (req_i.kind)
      KIND_APPEND: begin
        ctrl.pos = count_q[IDX_W-1:0];
        if (!full) begin
          ctrl.op = CELL_INSERT;
        end
      end
      KIND_INSERT: begin
        if (!full && idx_ext <= count_q) begin
          ctrl.op = CELL_INSERT;
        end
      end
      KIND_ERASE: begin
        if (idx_ext < count_q) begin
          ctrl.op = CELL_ERASE;
        end
      end
      default: ctrl.op = CELL_HOLD;
    endcase
    if (!accept) begin
      ctrl.op = CELL_HOLD;
    end
  end

  always_comb begin
    status_d = ST_DONE;
    rd_d     = '0;
    count_d  = count_q;
    case (req_i.kind)
      KIND_APPEND: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      KIND_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else if (idx_ext > count_q) begin
          status_d = ST_RANGE;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      KIND_ERASE: begin
        if (idx_ext >= count_q) begin
          status_d = ST_RANGE;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
      KIND_READ: begin
        if (idx_ext >= count_q) begin
          status_d = ST_RANGE;
        end else begin
          rd_d = tap_or;
        end
      end
      KIND_CLEAR: count_d = '0;
      default: count_d = count_q;
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [WORD_W-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = cell_data[g];
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = cell_data[g];
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end
    oaie_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pos_i   (IDX_W'(g)),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[g]),
      .tap_o   (cell_tap[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      rd_q        <= rd_d;
      out_count_q <= count_d;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.read_value = rd_q;
  assign rsp_o.count      = out_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_CNT)
    else $error("entry count beyond capacity");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.kind == KIND_CLEAR |=> count_q == '0 && rsp_o.count == '0)
    else $error("clear left entries");

  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && status_d != ST_DONE |=> count_q == $past(count_q))
    else $error("rejected item changed the count");

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> rsp_o.count == count_q)
    else $error("response count differs from entry count");

  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status != ST_DONE |-> rsp_o.read_value == '0)
    else $error("rejected item carries a word");

endmodule
